>>> rtl/cprg_pkg.sv
// Package for the circle point rotation generator.
// Register-port constants, register indexes and reset values; no dependencies.
package cprg_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  // fixed register widths
  localparam int unsigned CNT_REG_W = 16;
  localparam int unsigned COS_W     = 18;
  localparam int unsigned SIN_W     = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_COS_STEP    = 2'd1,
    REG_SIN_STEP    = 2'd2,
    REG_CLOCKWISE   = 2'd3
  } cfg_reg_e;

  localparam logic [CNT_REG_W-1:0]    POINT_COUNT_RST = 16'd8;
  localparam logic signed [COS_W-1:0] COS_STEP_RST    = 18'sd46341;
  localparam logic [SIN_W-1:0]        SIN_STEP_RST    = 17'd46341;
  localparam logic                    CLOCKWISE_RST   = 1'b1;

endpackage

>>> rtl/circle_point_rotation_generator.sv
// Circle point rotation generator: unit-circle vertices in triangle-strip order.
// Depends on cprg_pkg (register indexes, widths, reset values).
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ----------------------------------------
//  request   in         in_valid_i / in_ready_o    restart_i
//  result    out        out_valid_o / out_ready_i  x_out_o, y_out_o, circle_done_o, run_last_o
//  config    in         cfg_we_i (no handshake)    cfg_idx_i, cfg_data_i
//
// A request is decoded and the rotation done in the cycle it transfers; its first
// result is in the output register in the cycle after. A rotating request gives two
// results, the mirror following once the first is taken, and no new request is taken
// while the mirror is owed; requests with one or no result sustain one per cycle while
// the output is not stalled. The single output register plus the pending-mirror flag
// set these limits. Reset (async, active low) clears control state and loads the
// register reset values; no clearing pass. A stalled output holds the request side off.
module circle_point_rotation_generator #(
  parameter int unsigned COUNT_BITS    = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [cprg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cprg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // request
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                restart_i,
  // result
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [FRACTION_BITS+1:0]     x_out_o,
  output logic signed [FRACTION_BITS+1:0]     y_out_o,
  output logic                                circle_done_o,
  output logic                                run_last_o
);

  // point width: Q2.F
  localparam int unsigned PW     = FRACTION_BITS + 2;
  localparam int unsigned PROD_W = cprg_pkg::COS_W + PW;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned Q_W    = SUM_W - FRACTION_BITS;

  localparam logic signed [PW-1:0] P_MAX     = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN     = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [PW-1:0] P_ONE     = {2'b01, {FRACTION_BITS{1'b0}}};
  localparam logic signed [PW-1:0] P_NEG_ONE = {2'b11, {FRACTION_BITS{1'b0}}};
  localparam logic signed [SUM_W-1:0] RND_HALF =
    {{(SUM_W-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};

  // saturate a rounded sum to the point range
  function automatic logic signed [PW-1:0] sat_pt(input logic signed [Q_W-1:0] v);
    logic signed [PW-1:0] r;
    if (v > Q_W'(P_MAX)) begin
      r = P_MAX;
    end else if (v < Q_W'(P_MIN)) begin
      r = P_MIN;
    end else begin
      r = PW'(v);
    end
    return r;
  endfunction

  // negate with saturation (only the most negative code overflows)
  function automatic logic signed [PW-1:0] neg_pt(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    if (v == P_MIN) begin
      r = P_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [cprg_pkg::CNT_REG_W-1:0]    count_q;
  logic signed [cprg_pkg::COS_W-1:0] cos_q;
  logic [cprg_pkg::SIN_W-1:0]        sin_q;
  logic                              cw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= cprg_pkg::POINT_COUNT_RST;
      cos_q   <= cprg_pkg::COS_STEP_RST;
      sin_q   <= cprg_pkg::SIN_STEP_RST;
      cw_q    <= cprg_pkg::CLOCKWISE_RST;
    end else if (cfg_we_i) begin
      unique case (cprg_pkg::cfg_reg_e'(cfg_idx_i))
        cprg_pkg::REG_POINT_COUNT: count_q <= cfg_data_i[cprg_pkg::CNT_REG_W-1:0];
        cprg_pkg::REG_COS_STEP:    cos_q   <= $signed(cfg_data_i[cprg_pkg::COS_W-1:0]);
        cprg_pkg::REG_SIN_STEP:    sin_q   <= cfg_data_i[cprg_pkg::SIN_W-1:0];
        cprg_pkg::REG_CLOCKWISE:   cw_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Held point and circle progress
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]    cur_x_q, cur_y_q;
  logic [COUNT_BITS-1:0]   steps_q;
  logic                    active_q;

  // output register and pending mirror beat
  logic                    out_valid_q;
  logic signed [PW-1:0]    x_q, y_q;
  logic                    done_q, last_q;
  logic                    pend_q;       // mirror beat still owed
  logic                    pend_yaxis_q; // 1: mirror across y axis (negate x)
  logic                    pend_done_q;

  logic in_xfer, out_xfer;
  assign out_xfer   = out_valid_q & out_ready_i;
  assign in_ready_o = ~pend_q & (~out_valid_q | out_ready_i);
  assign in_xfer    = in_valid_i & in_ready_o;

  // ---------------------------------------------------------------------------
  // Rotation: x' = rnd(c*x + s*y), y' = rnd(c*y - s*x)
  // ---------------------------------------------------------------------------
  logic signed [cprg_pkg::COS_W-1:0] s_step;
  logic signed [PROD_W-1:0]          p_cx, p_sy, p_cy, p_sx;
  logic signed [SUM_W-1:0]           sum_x, sum_y;
  logic signed [Q_W-1:0]             q_x, q_y;
  logic signed [PW-1:0]              rot_x, rot_y;

  assign s_step = cw_q ?  $signed({1'b0, sin_q}) : -$signed({1'b0, sin_q});
  assign p_cx   = PROD_W'(cos_q)  * PROD_W'(cur_x_q);
  assign p_sy   = PROD_W'(s_step) * PROD_W'(cur_y_q);
  assign p_cy   = PROD_W'(cos_q)  * PROD_W'(cur_y_q);
  assign p_sx   = PROD_W'(s_step) * PROD_W'(cur_x_q);
  assign sum_x  = SUM_W'(p_cx) + SUM_W'(p_sy) + RND_HALF;
  assign sum_y  = SUM_W'(p_cy) - SUM_W'(p_sx) + RND_HALF;
  assign q_x    = Q_W'(sum_x >>> FRACTION_BITS); // floor after the half add
  assign q_y    = Q_W'(sum_y >>> FRACTION_BITS);
  assign rot_x  = sat_pt(q_x);
  assign rot_y  = sat_pt(q_y);

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] cnt_n, half_n;
  logic [COUNT_BITS:0]   steps_inc;
  logic                  odd_n, cnt_zero;

  assign cnt_n     = COUNT_BITS'(count_q);
  assign half_n    = cnt_n >> 1;
  assign odd_n     = cnt_n[0];
  assign cnt_zero  = (cnt_n == '0);
  assign steps_inc = {1'b0, steps_q} + (COUNT_BITS+1)'(1);

  logic                  emit, emit_two, do_rot, load_pt;
  logic signed [PW-1:0]  e_x, e_y, ld_x, ld_y;
  logic                  e_done, e_last, mir_yaxis, mir_done;
  logic                  active_d;
  logic [COUNT_BITS-1:0] steps_d;

  always_comb begin
    emit      = 1'b0;
    emit_two  = 1'b0;
    do_rot    = 1'b0;
    load_pt   = 1'b0;
    ld_x      = rot_x;
    ld_y      = rot_y;
    e_x       = rot_x;
    e_y       = rot_y;
    e_done    = 1'b0;
    e_last    = 1'b0;
    mir_yaxis = odd_n;
    mir_done  = 1'b0;
    active_d  = active_q;
    steps_d   = steps_q;
    priority if (restart_i) begin
      steps_d = '0;
      if (cnt_zero) begin
        active_d = 1'b0;
      end else begin
        load_pt  = 1'b1;
        ld_x     = odd_n ? '0 : P_ONE;
        ld_y     = odd_n ? P_ONE : '0;
        e_x      = ld_x;
        e_y      = ld_y;
        emit     = 1'b1;
        e_done   = (cnt_n == COUNT_BITS'(1));
        e_last   = 1'b1;
        active_d = ~e_done;
      end
    end else if (!active_q) begin
      // idle: nothing
    end else if (cnt_zero) begin
      active_d = 1'b0;
    end else if (odd_n) begin
      if (steps_q >= half_n) begin
        active_d = 1'b0;  // rotation budget already used up
      end else begin
        do_rot   = 1'b1;
        emit     = 1'b1;
        emit_two = 1'b1;
        steps_d  = COUNT_BITS'(steps_inc);
        mir_done = (steps_inc >= {1'b0, half_n});
        active_d = ~mir_done;
      end
    end else if (steps_inc < {1'b0, half_n}) begin
      do_rot   = 1'b1;
      emit     = 1'b1;
      emit_two = 1'b1;
      steps_d  = COUNT_BITS'(steps_inc);
    end else begin
      // even count closes on (-1,0)
      active_d = 1'b0;
      emit     = 1'b1;
      e_x      = P_NEG_ONE;
      e_y      = '0;
      e_done   = 1'b1;
      e_last   = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      steps_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (in_xfer) begin
        active_q <= active_d;
        steps_q  <= steps_d;
        if (load_pt || do_rot) begin
          cur_x_q <= ld_x;
          cur_y_q <= ld_y;
        end
      end
      // a new first beat replaces the one leaving in the same cycle
      if (in_xfer && emit) begin
        out_valid_q <= 1'b1;
        pend_q      <= emit_two;
      end else if (out_xfer) begin
        out_valid_q <= pend_q;
        pend_q      <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      x_q          <= e_x;
      y_q          <= e_y;
      done_q       <= e_done;
      last_q       <= e_last;
      pend_yaxis_q <= mir_yaxis;
      pend_done_q  <= mir_done;
    end else if (out_xfer && pend_q) begin
      // mirror of the held (just rotated) point
      x_q    <= pend_yaxis_q ? neg_pt(cur_x_q) : cur_x_q;
      y_q    <= pend_yaxis_q ? cur_y_q : neg_pt(cur_y_q);
      done_q <= pend_done_q;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign x_out_o       = x_q;
  assign y_out_o       = y_q;
  assign circle_done_o = done_q;
  assign run_last_o    = last_q;

endmodule

>>> rtl/cprg_checker.sv
// Port-level checker for the circle point rotation generator, with its bind.
// No package dependency; watches the request and result handshakes only.
module cprg_checker #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [FRACTION_BITS+1:0] x_out_o,
  input logic signed [FRACTION_BITS+1:0] y_out_o,
  input logic                            circle_done_o,
  input logic                            run_last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(x_out_o) && $stable(y_out_o)
      && $stable(circle_done_o) && $stable(run_last_o))
    else $error("result changed while stalled");

  // the mirror beat follows the first beat of a request at once
  a_mirror_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o)
    else $error("mirror beat did not follow");

  // no new request while results of the current one are owed
  a_no_req_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> !(in_ready_o && in_valid_i))
    else $error("request taken while results pending");

  // no request while the output is stalled
  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while output stalled");

  // circle end only on the closing beat of a request
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && circle_done_o |-> run_last_o)
    else $error("circle_done on a non-final beat");

endmodule

bind circle_point_rotation_generator cprg_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_cprg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .x_out_o       (x_out_o),
  .y_out_o       (y_out_o),
  .circle_done_o (circle_done_o),
  .run_last_o    (run_last_o)
);
